[hdl/trilinear_volume_sampler_assert.svh]
// ---------------------------------------------------------------------------
// trilinear_volume_sampler assertion macros
// Shared concurrent assertion forms for the sampler modules.
// ---------------------------------------------------------------------------
`ifndef TRILINEAR_VOLUME_SAMPLER_ASSERT_SVH
`define TRILINEAR_VOLUME_SAMPLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TVS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sampler assertion failed");
`define TVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sampler assertion failed");
`else
`define TVS_ASSERT_IMP(lbl, ante, cons)
`define TVS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/tvs_pkg.sv]
// ---------------------------------------------------------------------------
// tvs_pkg
// Types, constants and helper functions of the trilinear volume sampler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package tvs_pkg;

  localparam int IDX_W      = 8;
  localparam int SIZE_W     = 9;
  localparam int FRAC_W     = 8;
  localparam int WGT_W      = 9;
  localparam int VOX_W      = 16;
  localparam int COORD_W    = 16;
  localparam int OUT_W      = 40;
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int WIDX_W     = 5;
  localparam int DEF_MAX    = 32;
  localparam int FIFO_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICES = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET  = 6'd32;
  localparam logic [WGT_W-1:0] WEIGHT_ONE = 9'd256;

  typedef enum logic {BK_IDLE, BK_QUERY} back_state_t;

  typedef struct packed {
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [FRAC_W-1:0] frac;
  } axis_t;

  typedef struct packed {
    logic                    is_query;
    axis_t                   ax;
    axis_t                   ay;
    axis_t                   az;
    logic signed [VOX_W-1:0] value;
  } job_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rows;
    logic [SIZE_W-1:0] cols;
    logic [SIZE_W-1:0] slices;
  } sizes_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] r,
                                                 input logic [SIZE_W-1:0] mx);
    logic [SIZE_W-1:0] rx;
    rx = {{(SIZE_W-CFG_W){1'b0}}, r};
    if (rx == '0) return SIZE_W'(1);
    if (rx > mx) return mx;
    return rx;
  endfunction

  function automatic axis_t axis_split(input logic signed [COORD_W-1:0] c,
                                       input logic [SIZE_W-1:0] size);
    axis_t             a;
    logic [SIZE_W-1:0] top;
    logic [SIZE_W-1:0] ip;
    logic [SIZE_W-1:0] lo;
    logic [SIZE_W-1:0] lo1;
    top = size - SIZE_W'(1);
    ip  = {{(SIZE_W-7){1'b0}}, c[14:8]};
    a.frac = c[7:0];
    if (c[COORD_W-1]) begin
      lo = '0;
      a.frac = '0;
    end else if (ip >= top) begin
      lo = top;
      a.frac = '0;
    end else begin
      lo = ip;
    end
    lo1 = lo + SIZE_W'(1);
    a.lo = lo[IDX_W-1:0];
    a.hi = (lo1 < size) ? lo1[IDX_W-1:0] : top[IDX_W-1:0];
    return a;
  endfunction

endpackage

[hdl/tvs_front.sv]
// ---------------------------------------------------------------------------
// tvs_front
// Accepts beats, drops out-of-range writes and splits query coordinates.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tvs_front (
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic [tvs_pkg::WIDX_W-1:0]            row_index,
  input  logic [tvs_pkg::WIDX_W-1:0]            col_index,
  input  logic [tvs_pkg::WIDX_W-1:0]            slice_index,
  input  logic signed [tvs_pkg::VOX_W-1:0]      voxel_value,
  input  logic signed [tvs_pkg::COORD_W-1:0]    coord_x,
  input  logic signed [tvs_pkg::COORD_W-1:0]    coord_y,
  input  logic signed [tvs_pkg::COORD_W-1:0]    coord_z,
  input  tvs_pkg::sizes_t                       sizes,
  input  logic                                  q_full,
  output logic                                  q_push,
  output tvs_pkg::job_t                         q_job
);

  localparam int PADW = tvs_pkg::SIZE_W - tvs_pkg::WIDX_W;

  logic in_range;
  logic is_query;

  always_comb begin
    is_query = (cmd == tvs_pkg::CMD_QUERY);
    in_range = ({{PADW{1'b0}}, row_index} < sizes.rows) &&
               ({{PADW{1'b0}}, col_index} < sizes.cols) &&
               ({{PADW{1'b0}}, slice_index} < sizes.slices);
    in_ready = !q_full;
    q_push   = in_valid && !q_full && (is_query || in_range);
    q_job.is_query = is_query;
    q_job.value    = voxel_value;
    if (is_query) begin
      q_job.ax = tvs_pkg::axis_split(coord_x, sizes.rows);
      q_job.ay = tvs_pkg::axis_split(coord_y, sizes.cols);
      q_job.az = tvs_pkg::axis_split(coord_z, sizes.slices);
    end else begin
      q_job.ax = '{lo: tvs_pkg::IDX_W'(row_index), hi: '0, frac: '0};
      q_job.ay = '{lo: tvs_pkg::IDX_W'(col_index), hi: '0, frac: '0};
      q_job.az = '{lo: tvs_pkg::IDX_W'(slice_index), hi: '0, frac: '0};
    end
  end

endmodule

[hdl/tvs_queue.sv]
// ---------------------------------------------------------------------------
// tvs_queue
// Short job queue between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tvs_queue #(
  parameter int DEPTH = tvs_pkg::FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tvs_pkg::job_t job_in,
  output logic          full,
  input  logic          pop,
  output tvs_pkg::job_t job_out,
  output logic          empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tvs_pkg::job_t  slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign job_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= job_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

[hdl/tvs_back.sv]
// ---------------------------------------------------------------------------
// tvs_back
// Voxel memory, corner sequencer and weighted accumulation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "trilinear_volume_sampler_assert.svh"
module tvs_back #(
  parameter int MAX_ROWS   = tvs_pkg::DEF_MAX,
  parameter int MAX_COLS   = tvs_pkg::DEF_MAX,
  parameter int MAX_SLICES = tvs_pkg::DEF_MAX
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  tvs_pkg::job_t                     q_job,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tvs_pkg::OUT_W-1:0]  sample_out
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int AW = RW + CW + SW;
  localparam int WXY_W = 2 * tvs_pkg::WGT_W;
  localparam int W_W   = 3 * tvs_pkg::WGT_W;
  localparam int P_W   = tvs_pkg::VOX_W + W_W + 1;

  logic signed [tvs_pkg::VOX_W-1:0] mem [2**AW];

  tvs_pkg::back_state_t state, state_next;
  tvs_pkg::job_t        cur;
  logic [2:0]           corner;
  logic                 pipe_busy;
  logic                 start_query;
  logic                 do_write;
  logic                 issue;

  logic [AW-1:0]                    raddr;
  logic [AW-1:0]                    waddr;
  logic [tvs_pkg::WGT_W-1:0]        wx, wy, wz;
  logic signed [tvs_pkg::VOX_W-1:0] rd;

  logic                             s1_v, s1_first, s1_last;
  logic [WXY_W-1:0]                 s1_wxy;
  logic [tvs_pkg::WGT_W-1:0]        s1_wz;
  logic                             s2_v, s2_first, s2_last;
  logic [W_W-1:0]                   s2_w;
  logic signed [tvs_pkg::VOX_W-1:0] s2_vox;
  logic                             s3_v, s3_first, s3_last;
  logic signed [tvs_pkg::OUT_W-1:0] s3_prod;
  logic signed [tvs_pkg::OUT_W-1:0] acc;
  logic signed [tvs_pkg::OUT_W-1:0] acc_sum;
  logic signed [P_W-1:0]            prod_full;

  assign pipe_busy = (state == tvs_pkg::BK_QUERY) || s1_v || s2_v || s3_v;

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    start_query = 1'b0;
    do_write    = 1'b0;
    issue       = 1'b0;
    unique case (state)
      tvs_pkg::BK_IDLE: begin
        if (!q_empty) begin
          if (!q_job.is_query) begin
            q_pop    = 1'b1;
            do_write = 1'b1;
          end else if (!pipe_busy && !out_valid) begin
            q_pop       = 1'b1;
            start_query = 1'b1;
            state_next  = tvs_pkg::BK_QUERY;
          end
        end
      end
      tvs_pkg::BK_QUERY: begin
        issue = 1'b1;
        if (corner == 3'd7) state_next = tvs_pkg::BK_IDLE;
      end
      default: state_next = tvs_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    raddr = {(corner[2] ? cur.ax.hi[RW-1:0] : cur.ax.lo[RW-1:0]),
             (corner[1] ? cur.ay.hi[CW-1:0] : cur.ay.lo[CW-1:0]),
             (corner[0] ? cur.az.hi[SW-1:0] : cur.az.lo[SW-1:0])};
    waddr = {q_job.ax.lo[RW-1:0], q_job.ay.lo[CW-1:0], q_job.az.lo[SW-1:0]};
    wx = corner[2] ? {1'b0, cur.ax.frac} : tvs_pkg::WEIGHT_ONE - {1'b0, cur.ax.frac};
    wy = corner[1] ? {1'b0, cur.ay.frac} : tvs_pkg::WEIGHT_ONE - {1'b0, cur.ay.frac};
    wz = corner[0] ? {1'b0, cur.az.frac} : tvs_pkg::WEIGHT_ONE - {1'b0, cur.az.frac};
    prod_full = s2_vox * $signed({1'b0, s2_w});
    acc_sum = s3_first ? s3_prod : acc + s3_prod;
  end

  always_ff @(posedge clk) begin
    if (do_write) mem[waddr] <= q_job.value;
  end

  always_ff @(posedge clk) begin
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (start_query) cur <= q_job;
    s1_wxy  <= wx * wy;
    s1_wz   <= wz;
    s2_w    <= W_W'(s1_wxy * s1_wz);
    s2_vox  <= rd;
    s3_prod <= prod_full[tvs_pkg::OUT_W-1:0];
    if (s3_v) acc <= acc_sum;
    if (s3_v && s3_last) sample_out <= acc_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tvs_pkg::BK_IDLE;
      corner    <= '0;
      s1_v      <= 1'b0;
      s1_first  <= 1'b0;
      s1_last   <= 1'b0;
      s2_v      <= 1'b0;
      s2_first  <= 1'b0;
      s2_last   <= 1'b0;
      s3_v      <= 1'b0;
      s3_first  <= 1'b0;
      s3_last   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      corner   <= issue ? corner + 3'd1 : '0;
      s1_v     <= issue;
      s1_first <= issue && (corner == 3'd0);
      s1_last  <= issue && (corner == 3'd7);
      s2_v     <= s1_v;
      s2_first <= s1_first;
      s2_last  <= s1_last;
      s3_v     <= s2_v;
      s3_first <= s2_first;
      s3_last  <= s2_last;
      if (s3_v && s3_last) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  `TVS_ASSERT_IMP(a_start_out_free, start_query, !out_valid && !s3_v)
  `TVS_ASSERT_NEXT(a_last_sets_out, s3_v && s3_last, out_valid)
  `TVS_ASSERT_IMP(a_first_alone, s1_v && s1_first, !s2_v && !s3_v)
  `TVS_ASSERT_IMP(a_corner_idle, state == tvs_pkg::BK_IDLE, corner == 3'd0)

endmodule

[hdl/trilinear_volume_sampler.sv]
// ---------------------------------------------------------------------------
// trilinear_volume_sampler
// Voxel volume with an exact trilinear interpolating read port.
// ---------------------------------------------------------------------------
// A write beat stores one voxel in the back end; out-of-range writes are
// dropped at the front. A query beat occupies the back end while it reads
// its eight corner voxels in turn through the single memory read port,
// and the next query starts once its three-stage multiply-accumulate has
// drained and the result register is free, so a query also waits while
// the previous result has not been taken.
// Input beats keep flowing into a four-entry queue while the back end works, until the queue is full.
`timescale 1ns / 1ps
module trilinear_volume_sampler #(
  parameter int MAX_ROWS   = tvs_pkg::DEF_MAX,
  parameter int MAX_COLS   = tvs_pkg::DEF_MAX,
  parameter int MAX_SLICES = tvs_pkg::DEF_MAX
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tvs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tvs_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic [tvs_pkg::WIDX_W-1:0]           row_index,
  input  logic [tvs_pkg::WIDX_W-1:0]           col_index,
  input  logic [tvs_pkg::WIDX_W-1:0]           slice_index,
  input  logic signed [tvs_pkg::VOX_W-1:0]     voxel_value,
  input  logic signed [tvs_pkg::COORD_W-1:0]   coord_x,
  input  logic signed [tvs_pkg::COORD_W-1:0]   coord_y,
  input  logic signed [tvs_pkg::COORD_W-1:0]   coord_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tvs_pkg::OUT_W-1:0]     sample_out
);

  logic [tvs_pkg::CFG_W-1:0] rows_in_use;
  logic [tvs_pkg::CFG_W-1:0] cols_in_use;
  logic [tvs_pkg::CFG_W-1:0] slices_in_use;
  tvs_pkg::sizes_t           sizes;
  tvs_pkg::job_t             push_job;
  tvs_pkg::job_t             head_job;
  logic                      q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use   <= tvs_pkg::CFG_RESET;
      cols_in_use   <= tvs_pkg::CFG_RESET;
      slices_in_use <= tvs_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tvs_pkg::CFG_ROWS:   rows_in_use   <= cfg_data;
        tvs_pkg::CFG_COLS:   cols_in_use   <= cfg_data;
        tvs_pkg::CFG_SLICES: slices_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sizes.rows   = tvs_pkg::eff_size(rows_in_use, tvs_pkg::SIZE_W'(MAX_ROWS));
    sizes.cols   = tvs_pkg::eff_size(cols_in_use, tvs_pkg::SIZE_W'(MAX_COLS));
    sizes.slices = tvs_pkg::eff_size(slices_in_use, tvs_pkg::SIZE_W'(MAX_SLICES));
  end

  tvs_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .row_index   (row_index),
    .col_index   (col_index),
    .slice_index (slice_index),
    .voxel_value (voxel_value),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .sizes       (sizes),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  tvs_queue #(.DEPTH(tvs_pkg::FIFO_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .job_in  (push_job),
    .full    (q_full),
    .pop     (q_pop),
    .job_out (head_job),
    .empty   (q_empty)
  );

  tvs_back #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_SLICES (MAX_SLICES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

endmodule
